### design/lmrsd_pkg.sv
`default_nettype none

package lmrsd_pkg;

  // Chain and frame geometry.
  localparam int unsigned MAX_MODULES = 4;
  localparam int unsigned ROWS        = 8;
  localparam int unsigned DEV_W       = $clog2(MAX_MODULES);
  localparam int unsigned ROW_W       = $clog2(ROWS);
  localparam int unsigned ADDR_W      = DEV_W + ROW_W;
  localparam int unsigned DEPTH       = MAX_MODULES * ROWS;
  localparam int unsigned COUNT_W     = 3;

  // Command codes.
  localparam logic CMD_SET_ROW = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  // Fixed bytes of the clear sequence.
  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZEROS = 8'h00;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SEL,
    ST_DATA,
    ST_CLR_HI,
    ST_CLR_LO
  } state_t;

  // One byte handed to the serializer, with a flag for the final byte.
  typedef struct packed {
    logic       valid;
    logic [7:0] bits;
    logic       tail;
  } byte_req_t;

  // Frame store access from the sequencer.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

  // Active-low one-hot row select.
  function automatic logic [7:0] row_select(input logic [ROW_W-1:0] r);
    logic [7:0] onehot;
    onehot = 8'h01 << r;
    return ~onehot;
  endfunction

endpackage

`default_nettype wire

### design/lmrsd_ifs.sv
`default_nettype none

// Input word channel.
interface lmrsd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [lmrsd_pkg::DEV_W-1:0]   device;
  logic [lmrsd_pkg::ROW_W-1:0]   row;
  logic [7:0]                    row_data;

  modport source (output valid, command, device, row, row_data, input ready);
  modport sink   (input valid, command, device, row, row_data, output ready);
endinterface

// Output word channel, one word per shifted bit.
interface lmrsd_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic last;

  modport source (output valid, serial_bit, last, input ready);
  modport sink   (input valid, serial_bit, last, output ready);
endinterface

// Configuration write channel for the chain length register.
interface lmrsd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lmrsd_pkg::COUNT_W-1:0] device_count;

  modport source (output valid, device_count, input ready);
  modport sink   (input valid, device_count, output ready);
endinterface

`default_nettype wire

### design/lmrsd_frame_store.sv
`default_nettype none

module lmrsd_frame_store (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lmrsd_pkg::store_req_t        req,
  output logic [7:0]                        rd_data
);

  logic [7:0]                  mem [lmrsd_pkg::DEPTH];
  logic [lmrsd_pkg::DEPTH-1:0] filled;

  // Row byte memory; entries never written read as zero.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= filled[req.rd_addr] ? mem[req.rd_addr] : 8'h00;
    end
  end

  // Per-entry written flags, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (req.wr_en) begin
      filled[req.wr_addr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### design/lmrsd_serializer.sv
`default_nettype none

module lmrsd_serializer (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lmrsd_pkg::byte_req_t  ld,
  output logic                       ld_ready,
  lmrsd_out_if.source                out_ch
);

  logic       busy;
  logic [7:0] sh;
  logic [2:0] cnt;
  logic       tail;
  logic       bit_taken;
  logic       final_bit;

  assign final_bit = (cnt == 3'd7);
  assign bit_taken = busy && out_ch.ready;
  assign ld_ready  = !busy || (out_ch.ready && final_bit);

  // Shift register, LSB leaves first; a new byte loads as the old one ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ld.valid && ld_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (bit_taken) begin
      cnt <= cnt + 3'd1;
      if (final_bit) begin
        busy <= 1'b0;
      end
    end
  end

  // Payload of the shift register.
  always_ff @(posedge clk) begin
    if (ld.valid && ld_ready) begin
      sh   <= ld.bits;
      tail <= ld.tail;
    end else if (bit_taken) begin
      sh <= {1'b0, sh[7:1]};
    end
  end

  assign out_ch.valid      = busy;
  assign out_ch.serial_bit = sh[0];
  assign out_ch.last       = tail && final_bit;

endmodule

`default_nettype wire

### design/led_matrix_row_shift_driver_unit.sv
// LED matrix row shift driver.
// in_ch carries command words: a set-row word stores row_data for (device, row)
// in the frame store and then shifts, for each chained module from the last to
// the first, the active-low row-select byte and that module's stored row byte.
// A clear word shifts 0xFF then 0x00. Each out_ch word is one bit, LSB first;
// last marks the final bit of a command.
// cfg sets device_count (0 acts as 1, above 4 acts as 4) and is always ready;
// write it only while no command is in flight.
// A set-row word goes from idle through a frame-store write state before its
// select byte is loaded; a clear word loads 0xFF straight from idle. Throughput
// is one bit per cycle while out_ch is ready, through the 8-bit output shift
// register, so a set-row word shifts 16 bits per chained module (16 to 64) and
// a clear word 16 bits; the next word is taken while the previous one is still
// shifting and its bytes follow without a gap. When out_ch stalls the shift
// register holds its bit and the sequencer waits. Reset empties the frame store
// (all rows read as zero), sets device_count to 1 and drops any word in flight.
`default_nettype none

module led_matrix_row_shift_driver_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  lmrsd_in_if.sink    in_ch,
  lmrsd_out_if.source out_ch,
  lmrsd_cfg_if.sink   cfg
);

  lmrsd_pkg::state_t                state, state_next;
  logic [lmrsd_pkg::DEV_W-1:0]      m, m_next;
  logic [lmrsd_pkg::DEV_W-1:0]      m_start;
  logic [lmrsd_pkg::DEV_W-1:0]      dev_q;
  logic [lmrsd_pkg::ROW_W-1:0]      row_q;
  logic [7:0]                       data_q;
  logic [lmrsd_pkg::COUNT_W-1:0]    device_count;
  lmrsd_pkg::byte_req_t             ld;
  lmrsd_pkg::store_req_t            sreq;
  logic                             ld_ready;
  logic [7:0]                       rd_data;
  logic                             in_take;

  // Chain length register.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      device_count <= lmrsd_pkg::COUNT_W'(1);
    end else if (cfg.valid) begin
      device_count <= cfg.device_count;
    end
  end

  // Index of the last module in the chain, clamped to the valid range.
  always_comb begin
    if (device_count == '0) begin
      m_start = '0;
    end else if (device_count > lmrsd_pkg::COUNT_W'(lmrsd_pkg::MAX_MODULES)) begin
      m_start = lmrsd_pkg::DEV_W'(lmrsd_pkg::MAX_MODULES - 1);
    end else begin
      m_start = lmrsd_pkg::DEV_W'(device_count - lmrsd_pkg::COUNT_W'(1));
    end
  end

  assign in_ch.ready = (state == lmrsd_pkg::ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;

  // Captured word fields.
  always_ff @(posedge clk) begin
    if (in_take) begin
      dev_q  <= in_ch.device;
      row_q  <= in_ch.row;
      data_q <= in_ch.row_data;
    end
  end

  // Sequencer state and module counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmrsd_pkg::ST_IDLE;
      m     <= '0;
    end else begin
      state <= state_next;
      m     <= m_next;
    end
  end

  // Next state, byte requests and frame store accesses.
  always_comb begin
    state_next   = state;
    m_next       = m;
    ld.valid     = 1'b0;
    ld.bits      = lmrsd_pkg::BYTE_ZEROS;
    ld.tail      = 1'b0;
    sreq.wr_en   = 1'b0;
    sreq.wr_addr = {dev_q, row_q};
    sreq.wr_data = data_q;
    sreq.rd_en   = 1'b0;
    sreq.rd_addr = {m, row_q};
    unique case (state)
      lmrsd_pkg::ST_IDLE: begin
        if (in_take) begin
          m_next = m_start;
          if (in_ch.command == lmrsd_pkg::CMD_CLEAR) begin
            state_next = lmrsd_pkg::ST_CLR_HI;
          end else begin
            state_next = lmrsd_pkg::ST_WRITE;
          end
        end
      end
      lmrsd_pkg::ST_WRITE: begin
        sreq.wr_en = 1'b1;
        state_next = lmrsd_pkg::ST_SEL;
      end
      lmrsd_pkg::ST_SEL: begin
        // The module's row byte is fetched while the select byte waits.
        sreq.rd_en = 1'b1;
        ld.valid   = 1'b1;
        ld.bits    = lmrsd_pkg::row_select(row_q);
        if (ld_ready) begin
          state_next = lmrsd_pkg::ST_DATA;
        end
      end
      lmrsd_pkg::ST_DATA: begin
        ld.valid = 1'b1;
        ld.bits  = rd_data;
        ld.tail  = (m == '0);
        if (ld_ready) begin
          if (m == '0) begin
            state_next = lmrsd_pkg::ST_IDLE;
          end else begin
            m_next     = m - lmrsd_pkg::DEV_W'(1);
            state_next = lmrsd_pkg::ST_SEL;
          end
        end
      end
      lmrsd_pkg::ST_CLR_HI: begin
        ld.valid = 1'b1;
        ld.bits  = lmrsd_pkg::BYTE_ONES;
        if (ld_ready) begin
          state_next = lmrsd_pkg::ST_CLR_LO;
        end
      end
      lmrsd_pkg::ST_CLR_LO: begin
        ld.valid = 1'b1;
        ld.bits  = lmrsd_pkg::BYTE_ZEROS;
        ld.tail  = 1'b1;
        if (ld_ready) begin
          state_next = lmrsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lmrsd_pkg::ST_IDLE;
      end
    endcase
  end

  lmrsd_frame_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (sreq),
    .rd_data (rd_data)
  );

  lmrsd_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .ld       (ld),
    .ld_ready (ld_ready),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

### tb/row_shift_checker.sv
`default_nettype none

module row_shift_checker (
  input  wire logic    clk,
  input  wire logic    rst,
  lmrsd_in_if          in_mon,
  lmrsd_out_if         out_mon,
  lmrsd_cfg_if         cfg_mon,
  output int unsigned  fails,
  output int unsigned  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import lmrsd_pkg::*;

  // One shifted bit as it should appear on the output channel.
  typedef struct packed {
    logic serial_bit;
    logic last;
  } shift_bit_t;

  logic [7:0]         frame_rows [DEPTH];
  logic [COUNT_W-1:0] chain_setting;
  shift_bit_t         expected_bits [$];
  shift_bit_t         got;
  shift_bit_t         want;
  int unsigned        bit_count;

  // Queue the eight bits of one byte, LSB first.
  task automatic queue_byte(input logic [7:0] b, input logic tail_byte);
    for (int i = 0; i < 8; i++) begin
      expected_bits.push_back('{serial_bit: b[i], last: tail_byte && (i == 7)});
    end
  endtask

  // Work out the bit stream caused by one accepted command word.
  task automatic predict_word(input logic cmd, input logic [DEV_W-1:0] dev,
                              input logic [ROW_W-1:0] row, input logic [7:0] data);
    int         modules;
    logic [7:0] sel;
    if (chain_setting == 0) begin
      modules = 1;
    end else if (chain_setting > MAX_MODULES) begin
      modules = MAX_MODULES;
    end else begin
      modules = int'(chain_setting);
    end
    if (cmd == CMD_CLEAR) begin
      queue_byte(BYTE_ONES, 1'b0);
      queue_byte(BYTE_ZEROS, 1'b1);
    end else begin
      sel = ~(8'h01 << row);
      frame_rows[int'(dev) * ROWS + int'(row)] = data;
      // The far end of the chain goes out first.
      for (int m = modules - 1; m >= 0; m--) begin
        queue_byte(sel, 1'b0);
        queue_byte(frame_rows[m * ROWS + int'(row)], m == 0);
      end
    end
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        frame_rows[i] = 8'h00;
      end
      chain_setting = COUNT_W'(1);
      expected_bits.delete();
      fails = 0;
      bit_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        chain_setting = cfg_mon.device_count;
      end
      // Results leave before new commands are predicted.
      if (out_mon.valid && out_mon.ready) begin
        got = '{serial_bit: out_mon.serial_bit, last: out_mon.last};
        if (expected_bits.size() == 0) begin
          fails++;
          if (fails <= 40) begin
            $display("%0t: unexpected word: expected none, actual serial_bit=%0b last=%0b",
                     $time, got.serial_bit, got.last);
          end
        end else begin
          want = expected_bits.pop_front();
          if (got.serial_bit !== want.serial_bit) begin
            fails++;
            if (fails <= 40) begin
              $display("%0t: word %0d serial_bit: expected %0b, actual %0b",
                       $time, bit_count, want.serial_bit, got.serial_bit);
            end
          end
          if (got.last !== want.last) begin
            fails++;
            if (fails <= 40) begin
              $display("%0t: word %0d last: expected %0b, actual %0b",
                       $time, bit_count, want.last, got.last);
            end
          end
        end
        bit_count++;
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_word(in_mon.command, in_mon.device, in_mon.row, in_mon.row_data);
      end
    end
    pending = expected_bits.size();
  end

endmodule

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lmrsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned WORDS_PER_PHASE = 52;
  localparam int unsigned PHASES          = 9;

  logic        clk;
  logic        rst;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned fails;
  int unsigned pending;
  int unsigned cycle_count;

  lmrsd_in_if  in_ch ();
  lmrsd_out_if out_ch ();
  lmrsd_cfg_if cfg ();

  led_matrix_row_shift_driver_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  row_shift_checker stream_check (
    .clk     (clk),
    .rst     (rst),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .cfg_mon (cfg),
    .fails   (fails),
    .pending (pending)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: random stalls, or a long hold-off while hold_cycles runs down.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Offer one command word after a random gap and wait until it is taken.
  task automatic send_word(input logic cmd, input logic [DEV_W-1:0] dev,
                           input logic [ROW_W-1:0] row, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.device   <= dev;
    in_ch.row      <= row;
    in_ch.row_data <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Change the chain length once every pending bit has come out.
  task automatic write_chain_length(input logic [COUNT_W-1:0] n);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg.valid        <= 1'b1;
    cfg.device_count <= n;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    logic [COUNT_W-1:0] phase_counts [PHASES];
    logic               cmd;
    logic [7:0]         data;

    phase_counts = '{3'd4, 3'd2, 3'd0, 3'd7, 3'd3, 3'd1, 3'd5, 3'd6, 3'd4};
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_SET_ROW;
    in_ch.device     = '0;
    in_ch.row        = '0;
    in_ch.row_data   = 8'h00;
    cfg.valid        = 1'b0;
    cfg.device_count = '0;
    send_idle_pct    = 22;
    recv_idle_pct    = 58;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words with the chain length left at its reset value of one.
    send_word(CMD_CLEAR, 2'd3, 3'd7, 8'hFF);
    send_word(CMD_SET_ROW, 2'd0, 3'd0, 8'h00);
    send_word(CMD_SET_ROW, 2'd0, 3'd7, 8'hFF);
    send_word(CMD_SET_ROW, 2'd0, 3'd3, 8'hA5);
    // A module past the end of the chain still gets its byte stored.
    send_word(CMD_SET_ROW, 2'd3, 3'd5, 8'h5A);

    // Full chain: earlier stores come back out.
    write_chain_length(3'd4);
    send_word(CMD_SET_ROW, 2'd1, 3'd5, 8'h3C);
    send_word(CMD_SET_ROW, 2'd2, 3'd0, 8'h81);
    send_word(CMD_SET_ROW, 2'd3, 3'd7, 8'h7E);
    send_word(CMD_CLEAR, 2'd0, 3'd0, 8'h00);
    send_word(CMD_SET_ROW, 2'd0, 3'd7, 8'h01);

    // A chain length of zero behaves as one.
    write_chain_length(3'd0);
    send_word(CMD_SET_ROW, 2'd2, 3'd7, 8'h80);
    send_word(CMD_SET_ROW, 2'd0, 3'd2, 8'hC3);

    // Above four behaves as four.
    write_chain_length(3'd7);
    send_word(CMD_SET_ROW, 2'd1, 3'd0, 8'h55);
    send_word(CMD_CLEAR, 2'd2, 3'd4, 8'hAA);
    send_word(CMD_SET_ROW, 2'd2, 3'd7, 8'h0F);

    // Random phases, each at a chain length from phase_counts and one of three idle patterns.
    for (int p = 0; p < PHASES; p++) begin
      write_chain_length(phase_counts[p]);
      if (p < 3) begin
        send_idle_pct = 22;
        recv_idle_pct = 58;
      end else if (p < 6) begin
        send_idle_pct = 58;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Back up the whole pipe once, so the block has to stall its input.
      if (p == 0) begin
        hold_cycles = 300;
      end
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        cmd = ($urandom_range(99) < 15) ? CMD_CLEAR : CMD_SET_ROW;
        case ($urandom_range(9))
          0:       data = 8'h00;
          1:       data = 8'hFF;
          default: data = 8'($urandom_range(255));
        endcase
        send_word(cmd, DEV_W'($urandom_range(3)), ROW_W'($urandom_range(7)), data);
      end
    end

    // Drain and let any stray words show up.
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
